// ===== sv/ltis_pkg.sv =====
// ----------------------------------------------------------------------------
// ltis_pkg: shared types and constants for the layout token indent stack
// Holds the request and result words that travel between the front part,
// the back part and the result queue, plus the stack sizing constants.
// ----------------------------------------------------------------------------
package ltis_pkg;

  // stack sizing
  localparam int STACK_DEPTH = 256;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // column and paren depth widths
  localparam int COL_W   = 15;
  localparam int PAREN_W = 8;
  localparam logic [COL_W-1:0]   COL_MAX   = {COL_W{1'b1}};
  localparam logic [PAREN_W-1:0] PAREN_MAX = {PAREN_W{1'b1}};

  // mask bit positions
  localparam int MB_OPEN   = 0;
  localparam int MB_END    = 1;
  localparam int MB_CLOSE  = 2;
  localparam int MB_POPEN  = 3;
  localparam int MB_PCLOSE = 4;
  localparam int MB_LET    = 5;
  localparam logic [5:0] MASK_ALL = 6'h3F;

  // token kinds
  typedef enum logic [2:0] {
    KIND_OPEN   = 3'd0,
    KIND_END    = 3'd1,
    KIND_CLOSE  = 3'd2,
    KIND_POPEN  = 3'd3,
    KIND_PCLOSE = 3'd4,
    KIND_LET    = 3'd5
  } ltis_kind_t;

  // one stack entry
  typedef struct packed {
    logic [PAREN_W-1:0] pdepth;
    logic               is_let;
    logic [COL_W-1:0]   col;
  } ltis_entry_t;

  // classified request word
  typedef struct packed {
    logic [5:0]       mask;
    logic [COL_W-1:0] col;
    logic             col_zero;
    logic             nl;
    logic             eof;
    logic             ch_lparen;
    logic             ch_rparen;
    logic             ch_bar_plus;
    logic             in_kw;
  } ltis_req_t;

  // result word
  typedef struct packed {
    logic       emitted;
    logic [2:0] kind;
    logic       dropped;
  } ltis_res_t;

endpackage

// ===== sv/ltis_front.sv =====
// ----------------------------------------------------------------------------
// ltis_front: request intake and classification
// Clamps the column, reduces the boundary characters to a few flags and
// holds the classified words in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module ltis_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [5:0]        in_valid_mask,
  input  logic [15:0]       in_next_column,
  input  logic [7:0]        in_next_char,
  input  logic [7:0]        in_second_char,
  input  logic [7:0]        in_third_char,
  input  logic              in_crossed_newline,
  input  logic              in_end_of_input,
  output logic              full,
  output logic              req_valid,
  input  logic              req_take,
  output ltis_pkg::ltis_req_t req
);

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_N      = 8'h6E;

  function automatic logic is_ident(input logic [7:0] ch);
    return (ch inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
           ch == 8'h5F || ch == 8'h27;
  endfunction

  ltis_pkg::ltis_req_t cls;
  ltis_pkg::ltis_req_t ent_r [2];
  logic                wr_ptr_r, rd_ptr_r;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                wr_en;

  // classify the incoming word
  always_comb begin
    cls.mask        = in_valid_mask;
    cls.col         = in_next_column[15] ? ltis_pkg::COL_MAX
                                         : in_next_column[ltis_pkg::COL_W-1:0];
    cls.col_zero    = (in_next_column == 16'd0);
    cls.nl          = in_crossed_newline;
    cls.eof         = in_end_of_input;
    cls.ch_lparen   = (in_next_char == CH_LPAREN);
    cls.ch_rparen   = (in_next_char == CH_RPAREN);
    cls.ch_bar_plus = (in_next_char == CH_BAR) || (in_next_char == CH_PLUS);
    cls.in_kw       = (in_next_char == CH_I) && (in_second_char == CH_N) &&
                      !is_ident(in_third_char);
  end

  // queue control
  assign full      = (cnt_r == 2'd2);
  assign req_valid = (cnt_r != 2'd0);
  assign req       = ent_r[rd_ptr_r];
  assign wr_en     = push && !full;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !req_take) cnt_nxt = cnt_r + 2'd1;
    else if (!wr_en && req_take) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (req_take) rd_ptr_r <= ~rd_ptr_r;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) ent_r[wr_ptr_r] <= cls;
  end

endmodule

// ===== sv/ltis_back.sv =====
// ----------------------------------------------------------------------------
// ltis_back: indent stack and token rules
// Applies the layout rules to one classified word per cycle, while the result
// queue is not full, against a cached top entry; entries below the top live in a
// memory with a registered read of the entry just under the top.
// ----------------------------------------------------------------------------
module ltis_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  input  ltis_pkg::ltis_req_t req,
  output logic                req_take,
  input  logic                res_full,
  output ltis_pkg::ltis_res_t res
);

  ltis_pkg::ltis_entry_t mem [ltis_pkg::STACK_DEPTH];
  ltis_pkg::ltis_entry_t top_r, mem_q_r, byp_data_r, below, new_entry;
  logic                  byp_r;
  logic [ltis_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [ltis_pkg::PAREN_W-1:0] parens_r, parens_nxt;
  logic [ltis_pkg::ADDR_W-1:0]  wr_addr, rd_addr;
  logic do_push, do_pop, handled, is_open, is_let, want_end, want_close;
  logic stack_full, stack_live;

  assign req_take   = req_valid && !res_full;
  assign below      = byp_r ? byp_data_r : mem_q_r;
  assign stack_full = (count_r == ltis_pkg::CNT_W'(ltis_pkg::STACK_DEPTH));
  assign stack_live = (count_r != '0);

  // token rules
  always_comb begin
    res        = '0;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    handled    = 1'b0;
    parens_nxt = parens_r;
    is_let     = req.mask[ltis_pkg::MB_LET];
    is_open    = req.mask[ltis_pkg::MB_OPEN] || is_let;
    want_end   = req.mask[ltis_pkg::MB_END];
    want_close = req.mask[ltis_pkg::MB_CLOSE];
    new_entry.pdepth = parens_r;
    new_entry.is_let = is_let;
    new_entry.col    = req.eof ? '0 : req.col;

    if (req.mask == ltis_pkg::MASK_ALL) begin
      // error recovery: nothing
    end else if (is_open) begin
      res.emitted = 1'b1;
      res.kind    = is_let ? ltis_pkg::KIND_LET : ltis_pkg::KIND_OPEN;
      res.dropped = stack_full;
      do_push     = !stack_full;
    end else begin
      // layout rules against the top entry
      if (stack_live && (want_end || want_close) && !(parens_r > top_r.pdepth)) begin
        if (req.eof) begin
          if (want_close) begin
            handled = 1'b1;
            do_pop  = 1'b1;
            res.kind = ltis_pkg::KIND_CLOSE;
          end else begin
            handled = 1'b1;
            res.kind = ltis_pkg::KIND_END;
          end
        end else if (want_close && req.ch_rparen && top_r.pdepth != '0 &&
                     parens_r == top_r.pdepth) begin
          handled  = 1'b1;
          do_pop   = 1'b1;
          res.kind = ltis_pkg::KIND_CLOSE;
        end else if (req.col < top_r.col && req.nl) begin
          if (!req.ch_bar_plus && want_close) begin
            handled  = 1'b1;
            do_pop   = 1'b1;
            res.kind = ltis_pkg::KIND_CLOSE;
          end
        end else if (req.col == top_r.col && req.nl) begin
          if (want_end) begin
            handled  = 1'b1;
            res.kind = ltis_pkg::KIND_END;
          end
        end else begin
          // 'in' keyword closes a let block
          if (want_close && top_r.is_let && parens_r == top_r.pdepth && req.in_kw) begin
            handled  = 1'b1;
            do_pop   = 1'b1;
            res.kind = ltis_pkg::KIND_CLOSE;
          end
        end
      end
      // paren tracking and top-level end
      if (handled) begin
        res.emitted = 1'b1;
      end else if (!req.eof && req.ch_lparen && req.mask[ltis_pkg::MB_POPEN]) begin
        res.emitted = 1'b1;
        res.kind    = ltis_pkg::KIND_POPEN;
        if (parens_r != ltis_pkg::PAREN_MAX)
          parens_nxt = parens_r + ltis_pkg::PAREN_W'(1);
      end else if (!req.eof && req.ch_rparen && req.mask[ltis_pkg::MB_PCLOSE]) begin
        res.emitted = 1'b1;
        res.kind    = ltis_pkg::KIND_PCLOSE;
        if (parens_r != '0) parens_nxt = parens_r - ltis_pkg::PAREN_W'(1);
      end else if (want_end && !stack_live && req.nl && (req.col_zero || req.eof)) begin
        res.emitted = 1'b1;
        res.kind    = ltis_pkg::KIND_END;
      end
    end
  end

  // next stack count and memory addresses
  always_comb begin
    count_nxt = count_r;
    if (req_take && do_push) count_nxt = count_r + ltis_pkg::CNT_W'(1);
    else if (req_take && do_pop) count_nxt = count_r - ltis_pkg::CNT_W'(1);
    wr_addr = ltis_pkg::ADDR_W'(count_r - ltis_pkg::CNT_W'(1));
    rd_addr = ltis_pkg::ADDR_W'(count_nxt - ltis_pkg::CNT_W'(2));
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      parens_r <= '0;
      byp_r    <= 1'b0;
    end else begin
      byp_r <= req_take && do_push;
      if (req_take) begin
        count_r  <= count_nxt;
        parens_r <= parens_nxt;
      end
    end
  end

  // cached top entry
  always_ff @(posedge clk) begin
    byp_data_r <= top_r;
    if (req_take && do_push) top_r <= new_entry;
    else if (req_take && do_pop) top_r <= below;
  end

  // entries below the top; read of the one under the next top
  always_ff @(posedge clk) begin
    if (req_take && do_push && stack_live) mem[wr_addr] <= top_r;
    mem_q_r <= mem[rd_addr];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ltis_pkg::CNT_W'(ltis_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_drop_open: assert property (@(posedge clk) disable iff (!rst_n)
    req_take && res.dropped |-> res.emitted && is_open && stack_full)
    else $error("dropped push without open on full stack");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    req_take && do_pop |=> count_r == $past(count_r) - ltis_pkg::CNT_W'(1))
    else $error("pop did not lower the count");

  a_pop_live: assert property (@(posedge clk) disable iff (!rst_n)
    req_take && do_pop |-> stack_live && !do_push)
    else $error("pop on empty stack");

endmodule

// ===== sv/ltis_res_q.sv =====
// ----------------------------------------------------------------------------
// ltis_res_q: result queue
// Two-entry queue that holds finished result words until they are popped,
// so the back part keeps working while the consumer stalls.
// ----------------------------------------------------------------------------
module ltis_res_q (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  ltis_pkg::ltis_res_t wr_data,
  output logic                q_full,
  input  logic                pop,
  output logic                empty,
  output ltis_pkg::ltis_res_t head
);

  ltis_pkg::ltis_res_t ent_r [2];
  logic                wr_ptr_r, rd_ptr_r, rd_en;
  logic [1:0]          cnt_r, cnt_nxt;

  assign q_full = (cnt_r == 2'd2);
  assign empty  = (cnt_r == 2'd0);
  assign head   = ent_r[rd_ptr_r];
  assign rd_en  = pop && !empty;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) cnt_nxt = cnt_r + 2'd1;
    else if (!wr_en && rd_en) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) ent_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== sv/layout_token_indent_stack.sv =====
// ----------------------------------------------------------------------------
// layout_token_indent_stack: offside-rule layout token scanner
// A pushed word is registered in the front queue and its result in the result queue before it reaches the out_ ports.
// Throughput: one request per cycle while the result queue has room; the back part
// takes one classified word per cycle, set by the combinational rule check against the top entry.
// Reset (rst_n low, synchronous) empties both queues and clears the stack
// count and paren depth; the stack memory is not cleared.
// ----------------------------------------------------------------------------
module layout_token_indent_stack (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [5:0]  in_valid_mask,
  input  logic [15:0] in_next_column,
  input  logic [7:0]  in_next_char,
  input  logic [7:0]  in_second_char,
  input  logic [7:0]  in_third_char,
  input  logic        in_crossed_newline,
  input  logic        in_end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic        out_emitted,
  output logic [2:0]  out_token_kind,
  output logic        out_push_dropped
);

  ltis_pkg::ltis_req_t req;
  ltis_pkg::ltis_res_t res, head;
  logic req_valid, req_take, res_full;

  // front: intake and classification
  ltis_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .in_valid_mask      (in_valid_mask),
    .in_next_column     (in_next_column),
    .in_next_char       (in_next_char),
    .in_second_char     (in_second_char),
    .in_third_char      (in_third_char),
    .in_crossed_newline (in_crossed_newline),
    .in_end_of_input    (in_end_of_input),
    .full               (full),
    .req_valid          (req_valid),
    .req_take           (req_take),
    .req                (req)
  );

  // back: stack and rules
  ltis_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take),
    .res_full  (res_full),
    .res       (res)
  );

  // result queue
  ltis_res_q u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (req_take),
    .wr_data (res),
    .q_full  (res_full),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  assign out_emitted      = head.emitted;
  assign out_token_kind   = head.kind;
  assign out_push_dropped = head.dropped;

endmodule
